/* hw/rtl/ssca_pkg.sv */
// ssca_pkg: shared types, constants and helpers of the slab size-class allocator.
// No dependencies; every other file of the block but ssca_stream_if imports it.
package ssca_pkg;

	localparam int ADDR_W         = 18;
	localparam int SIZE_W         = 24;
	localparam int STATUS_W       = 3;
	localparam int PCOUNT_W       = 13;
	localparam int CLASS_W        = 3;
	localparam int NUM_CLASSES    = 8;
	localparam int PAGE_BYTES     = 4096;
	localparam int OFFS_W         = 12;
	localparam int PAGE_IDX_W     = ADDR_W - OFFS_W;
	localparam int CELL_SHIFT     = 3;
	localparam int CELL_IDX_W     = ADDR_W - CELL_SHIFT;
	localparam int CELLS_PER_PAGE = PAGE_BYTES / 8;
	localparam int MAX_CELLS      = 1 << CELL_IDX_W;
	localparam int LARGE_LIMIT    = 1024;
	localparam int SLOT_W         = 11;
	localparam int MIN_SLOT       = 8;
	localparam int DEF_POOL_PAGES = 64;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANT     = 3'd0,
		ST_LARGE     = 3'd1,
		ST_NO_PAGE   = 3'd2,
		ST_FREED     = 3'd3,
		ST_PAGE_FREE = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		func_t              func;
		logic [SIZE_W-1:0]  req_size;
		logic [ADDR_W-1:0]  free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		status_t             status;
		logic [PCOUNT_W-1:0] page_count;
	} rsp_t;

	// slot size of a class: 8 << c
	function automatic logic [SLOT_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
		return SLOT_W'(MIN_SLOT) << c;
	endfunction

	// first class whose slot is strictly larger than the request, capped at the top class
	function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] req);
		logic [CLASS_W-1:0] cls;
		cls = '0;
		for (int i = 0; i < NUM_CLASSES - 1; i++) begin
			if (req >= SIZE_W'(class_bytes(CLASS_W'(i))))
				cls = CLASS_W'(i + 1);
		end
		return cls;
	endfunction

endpackage

/* hw/rtl/ssca_stream_if.sv */
// ssca_stream_if: valid/ready channel carrying one payload beat.
// Payload type is set per instance; used with ssca_pkg::req_t and rsp_t.
interface ssca_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/slab_size_class_allocator.sv */
// slab_size_class_allocator: top level of the slab allocator with eight
// power-of-two size classes. Depends on ssca_pkg, ssca_stream_if,
// ssca_link_mem and ssca_tag_mem.
//
// Usage:
//  - req (sink): one beat is an allocate (func=0, req_size) or a free
//    (func=1, free_addr). rsp (source): exactly one beat per request with
//    addr, status and page_count.
//  - Timing: the link and tag RAMs are read at the edge that takes a request;
//    the execute state then updates the class state and registers the
//    response, and rsp.valid rises with the response register.
//  - A new request is taken only after the read-modify-write of a class
//    free list through the registered link RAM read has written back, so
//    no forwarding is needed.
//  - Stall: the response waits in the output register; a new request is
//    taken once that register is empty or drained in the same cycle.
//  - Reset: free lists empty, class i carves from the top slot of page i,
//    eight pages taken. No clearing pass; link RAM data is used only from
//    cells written by an earlier free.
module slab_size_class_allocator
	import ssca_pkg::*;
#(
	parameter int POOL_PAGES = DEF_POOL_PAGES
) (
	input  logic           clk,
	input  logic           arst_n,
	ssca_stream_if.sink    req,
	ssca_stream_if.source  rsp
);

	localparam int PAGE_W     = $clog2(POOL_PAGES);
	localparam int PT_W       = $clog2(POOL_PAGES + 1);
	localparam int CUR_W      = (OFFS_W + PAGE_W > ADDR_W) ? OFFS_W + PAGE_W : ADDR_W;
	localparam int LINK_DEPTH = (POOL_PAGES * CELLS_PER_PAGE < MAX_CELLS)
	                            ? POOL_PAGES * CELLS_PER_PAGE : MAX_CELLS;
	localparam int LINK_AW    = $clog2(LINK_DEPTH);

	// control
	state_t state_q, state_d;
	logic   in_ready, accept, load_rsp;

	// request captured at acceptance
	func_t              func_s1;
	logic [SIZE_W-1:0]  size_s1;
	logic [ADDR_W-1:0]  faddr_s1;
	logic [CLASS_W-1:0] class_s1;

	// class state
	logic [ADDR_W-1:0] head_q   [NUM_CLASSES];
	logic [CUR_W-1:0]  cursor_q [NUM_CLASSES];
	logic [PT_W-1:0]   pages_q;

	// response register
	rsp_t rsp_q, rsp_d;
	logic rsp_vld_q;

	// memory ports
	logic               link_we;
	logic [LINK_AW-1:0] link_waddr, link_raddr;
	logic [ADDR_W-1:0]  link_rdata;
	logic               tag_we;
	logic [CLASS_W-1:0] tag_class;

	// head read port: one address per cycle
	logic [CLASS_W-1:0] class_a, head_ridx;
	logic [ADDR_W-1:0]  head_rd;

	// update controls
	logic               head_we;
	logic [CLASS_W-1:0] head_widx;
	logic [ADDR_W-1:0]  head_wdata;
	logic               cur_we;
	logic [CUR_W-1:0]   cur_wdata;
	logic               pages_inc;

	// execute-cycle terms
	logic [PAGE_IDX_W-1:0] free_page;
	logic                  in_pool;
	logic [SLOT_W-1:0]     sz;
	logic [CUR_W-1:0]      cur_rd, new_top, grant;

	assign class_a   = class_of(req.data.req_size);
	assign head_ridx = (state_q == S_IDLE) ? class_a
	                 : ((func_s1 == FN_FREE) ? tag_class : class_s1);
	assign head_rd   = head_q[head_ridx];

	assign accept     = req.valid && in_ready;
	assign link_raddr = head_rd[LINK_AW+CELL_SHIFT-1:CELL_SHIFT];
	assign link_waddr = faddr_s1[LINK_AW+CELL_SHIFT-1:CELL_SHIFT];

	assign free_page = faddr_s1[ADDR_W-1:OFFS_W];
	assign in_pool   = ({{PT_W{1'b0}}, free_page} < (PT_W + PAGE_IDX_W)'(POOL_PAGES));
	assign sz        = class_bytes(class_s1);
	assign cur_rd    = cursor_q[class_s1];
	assign new_top   = CUR_W'({pages_q[PAGE_W-1:0], OFFS_W'(0) - OFFS_W'(sz)});

	ssca_link_mem #(
		.DEPTH (LINK_DEPTH),
		.AW    (LINK_AW)
	) u_link_mem (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (head_rd),
		.re    (accept),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	ssca_tag_mem #(
		.POOL_PAGES (POOL_PAGES),
		.PAGE_W     (PAGE_W)
	) u_tag_mem (
		.clk    (clk),
		.we     (tag_we),
		.waddr  (pages_q[PAGE_W-1:0]),
		.wclass (class_s1),
		.re     (accept),
		.rpage  (req.data.free_addr[ADDR_W-1:OFFS_W]),
		.rclass (tag_class)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs and updates per state
	always_comb begin
		in_ready   = 1'b0;
		load_rsp   = 1'b0;
		link_we    = 1'b0;
		tag_we     = 1'b0;
		head_we    = 1'b0;
		head_widx  = head_ridx;
		head_wdata = faddr_s1;
		cur_we     = 1'b0;
		cur_wdata  = cur_rd;
		pages_inc  = 1'b0;
		grant      = cur_rd;
		rsp_d      = '{addr: '0, status: ST_GRANT, page_count: '0};
		case (state_q)
			S_IDLE: begin
				in_ready = !rsp_vld_q || rsp.ready;
			end
			S_EXEC: begin
				load_rsp = 1'b1;
				if (func_s1 == FN_FREE) begin
					if (faddr_s1[OFFS_W-1:0] == '0) begin
						// whole page goes back to the outside page allocator
						rsp_d.addr   = faddr_s1;
						rsp_d.status = ST_PAGE_FREE;
					end else begin
						rsp_d.status = ST_FREED;
						if (in_pool) begin
							link_we    = 1'b1;
							head_we    = 1'b1;
							head_wdata = faddr_s1;
						end
					end
				end else if (size_s1 >= SIZE_W'(LARGE_LIMIT)) begin
					rsp_d.status     = ST_LARGE;
					rsp_d.page_count = PCOUNT_W'(size_s1[SIZE_W-1:OFFS_W])
					                 + PCOUNT_W'(size_s1[OFFS_W-1:0] != '0);
				end else if (head_rd != '0) begin
					// pop: next link was read at acceptance
					head_we    = 1'b1;
					head_wdata = link_rdata;
					rsp_d.addr = head_rd;
				end else if (cur_rd[OFFS_W-1:0] == '0) begin
					// current page used up
					if (pages_q >= PT_W'(POOL_PAGES)) begin
						rsp_d.status = ST_NO_PAGE;
					end else begin
						tag_we     = 1'b1;
						pages_inc  = 1'b1;
						grant      = new_top;
						cur_we     = 1'b1;
						cur_wdata  = new_top - CUR_W'(sz);
						rsp_d.addr = new_top[ADDR_W-1:0];
					end
				end else begin
					cur_we     = 1'b1;
					cur_wdata  = grant - CUR_W'(sz);
					rsp_d.addr = grant[ADDR_W-1:0];
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
			pages_q   <= PT_W'(NUM_CLASSES);
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i]   <= '0;
				cursor_q[i] <= CUR_W'({PAGE_W'(i),
					OFFS_W'(0) - OFFS_W'(class_bytes(CLASS_W'(i)))});
			end
		end else begin
			state_q <= state_d;
			if (load_rsp)
				rsp_vld_q <= 1'b1;
			else if (rsp.ready)
				rsp_vld_q <= 1'b0;
			if (head_we)
				head_q[head_widx] <= head_wdata;
			if (cur_we)
				cursor_q[class_s1] <= cur_wdata;
			if (pages_inc)
				pages_q <= pages_q + PT_W'(1);
		end
	end

	// request capture and response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= req.data.func;
			size_s1  <= req.data.req_size;
			faddr_s1 <= req.data.free_addr;
			class_s1 <= class_a;
		end
		if (load_rsp)
			rsp_q <= rsp_d;
	end

	assign req.ready = in_ready;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

endmodule

/* hw/rtl/ssca_link_mem.sv */
// ssca_link_mem: single-port-write, single-port-read RAM holding free-list links.
// Read data registered. Depends on ssca_pkg.
module ssca_link_mem
	import ssca_pkg::*;
#(
	parameter int DEPTH = DEF_POOL_PAGES * CELLS_PER_PAGE,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [ADDR_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [ADDR_W-1:0] rdata
);

	logic [ADDR_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ssca_tag_mem.sv */
// ssca_tag_mem: per-page class tag RAM with registered read.
// The first NUM_CLASSES pages are tagged with their own index from reset on.
// Depends on ssca_pkg.
module ssca_tag_mem
	import ssca_pkg::*;
#(
	parameter int POOL_PAGES = DEF_POOL_PAGES,
	parameter int PAGE_W     = $clog2(POOL_PAGES)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [PAGE_W-1:0]     waddr,
	input  logic [CLASS_W-1:0]    wclass,
	input  logic                  re,
	input  logic [PAGE_IDX_W-1:0] rpage,
	output logic [CLASS_W-1:0]    rclass
);

	logic [CLASS_W-1:0]          mem [POOL_PAGES];
	logic [CLASS_W-1:0]          rd_q;
	logic                        low_q;
	logic [CLASS_W-1:0]          low_cls_q;
	logic [PAGE_W+PAGE_IDX_W-1:0] rpage_wide;
	logic [PAGE_W-1:0]           ridx;

	assign rpage_wide = {{PAGE_W{1'b0}}, rpage};
	assign ridx       = rpage_wide[PAGE_W-1:0];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wclass;
		if (re) begin
			rd_q      <= mem[ridx];
			low_q     <= (rpage < PAGE_IDX_W'(NUM_CLASSES));
			low_cls_q <= rpage[CLASS_W-1:0];
		end
	end

	// boot pages are never re-taken, so their tag is fixed
	assign rclass = low_q ? low_cls_q : rd_q;

endmodule

/* hw/rtl/ssca_checker.sv */
// ssca_port_checker: port-level assertions for slab_size_class_allocator,
// attached by bind. Depends on ssca_pkg.
module ssca_port_checker
	import ssca_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// a waiting response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response beat dropped or changed while stalled");

	// one request in flight: no acceptance right after one
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one executing");

	// every request answered once the execute state loads the response register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("response missing two cycles after request");

	// only grants and page frees carry an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_LARGE || rsp_data.status == ST_NO_PAGE
		|| rsp_data.status == ST_FREED) |-> rsp_data.addr == '0)
		else $error("address set on a non-grant response");

	// page count only on large requests, and then nonzero
	a_page_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_data.status == ST_LARGE) == (rsp_data.page_count != '0)))
		else $error("page count inconsistent with status");

endmodule

bind slab_size_class_allocator ssca_port_checker u_ssca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

/* sim/ssca_checker.sv */
// ssca_checker: predicts every response of the slab size-class allocator and
// compares it, field by field, with the beats seen on the rsp channel.
// Depends on ssca_pkg; instantiated by tb_top next to the block.
`timescale 1ns / 100ps

module ssca_checker
	import ssca_pkg::*;
#(
	parameter int POOL_PAGES = DEF_POOL_PAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_beat,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_beat,
	output int   fail_count,
	output int   due_count
);

	localparam int LINK_CELLS = POOL_PAGES * PAGE_BYTES / 8;

	// allocator state as the predictor sees it
	logic [ADDR_W-1:0]  list_head [NUM_CLASSES];
	logic [ADDR_W-1:0]  carve_at  [NUM_CLASSES];
	logic [CLASS_W-1:0] page_tag  [POOL_PAGES];
	logic [ADDR_W-1:0]  cell_link [LINK_CELLS];
	int                 pages_used;

	rsp_t due_rsp_q [$];
	rsp_t owed;
	int   fails = 0;
	int   beat_no;

	assign fail_count = fails;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fails++;
		$display("%0t: rsp beat %0d, %s: got 0x%0h, want 0x%0h",
			$time, beat_no, what, got, want);
	endtask

	// response to one request beat; updates the predicted state
	function automatic rsp_t next_slab_rsp(input req_t b);
		rsp_t               r;
		logic [CLASS_W-1:0] cls;
		logic [ADDR_W-1:0]  grant;
		int                 slot;
		int                 page;

		r = '{addr: '0, status: ST_FREED, page_count: '0};

		if (b.func == FN_FREE) begin
			if (b.free_addr[OFFS_W-1:0] == '0) begin
				r.addr   = b.free_addr;
				r.status = ST_PAGE_FREE;
				return r;
			end
			page = int'(b.free_addr[ADDR_W-1:OFFS_W]);
			if (page < POOL_PAGES) begin
				cls = page_tag[page];
				cell_link[b.free_addr[ADDR_W-1:CELL_SHIFT]] = list_head[cls];
				list_head[cls] = b.free_addr;
			end
			return r;
		end

		if (b.req_size >= SIZE_W'(LARGE_LIMIT)) begin
			r.status     = ST_LARGE;
			r.page_count = PCOUNT_W'((int'(b.req_size) + PAGE_BYTES - 1) / PAGE_BYTES);
			return r;
		end

		cls  = '0;
		slot = MIN_SLOT;
		while (cls < CLASS_W'(NUM_CLASSES - 1) && slot <= int'(b.req_size)) begin
			cls++;
			slot = slot * 2;
		end

		r.status = ST_GRANT;
		if (list_head[cls] != '0) begin
			grant          = list_head[cls];
			list_head[cls] = cell_link[grant[ADDR_W-1:CELL_SHIFT]];
			r.addr         = grant;
			return r;
		end

		// current page used up: take a fresh one or give up
		if (carve_at[cls][OFFS_W-1:0] == '0) begin
			if (pages_used >= POOL_PAGES) begin
				r.status = ST_NO_PAGE;
				return r;
			end
			page_tag[pages_used] = cls;
			carve_at[cls] = ADDR_W'((pages_used + 1) * PAGE_BYTES - slot);
			pages_used++;
		end
		grant         = carve_at[cls];
		carve_at[cls] = grant - ADDR_W'(slot);
		r.addr        = grant;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				list_head[c] = '0;
				carve_at[c]  = ADDR_W'(c * PAGE_BYTES + PAGE_BYTES - (MIN_SLOT << c));
			end
			for (int p = 0; p < POOL_PAGES; p++)
				page_tag[p] = (p < NUM_CLASSES) ? CLASS_W'(p) : '0;
			pages_used = NUM_CLASSES;
			due_rsp_q.delete();
			beat_no = 0;
			due_count <= 0;
		end else begin
			// responses first: a beat leaving now belongs to an older request
			if (rsp_valid && rsp_ready) begin
				if (due_rsp_q.size() == 0) begin
					report_mismatch("beat with nothing due", 32'(rsp_beat.addr), 32'd0);
				end else begin
					owed = due_rsp_q.pop_front();
					if (rsp_beat.addr !== owed.addr)
						report_mismatch("addr", 32'(rsp_beat.addr), 32'(owed.addr));
					if (rsp_beat.status !== owed.status)
						report_mismatch("status", 32'(rsp_beat.status), 32'(owed.status));
					if (rsp_beat.page_count !== owed.page_count)
						report_mismatch("page_count", 32'(rsp_beat.page_count),
							32'(owed.page_count));
				end
				beat_no++;
			end
			if (req_valid && req_ready)
				due_rsp_q.push_back(next_slab_rsp(req_beat));
			due_count <= due_rsp_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// tb_top: stimulus and verdict for slab_size_class_allocator.
// Depends on ssca_pkg, ssca_stream_if, the block itself and ssca_checker.
`timescale 1ns / 100ps

module tb_top;
	import ssca_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	// margin before the verdict
	localparam int DRAIN_CYCLES = 16;
	localparam int LAST_PAGE    = DEF_POOL_PAGES - 1;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   rsp_due;
	int   cycle_no = 0;

	// sender: beats left in a stretch without gaps
	int tx_run = 0;
	// receiver: cycles of stall left, and of forced ready left
	int rx_hold;
	int rx_run;
	int rx_roll;

	// cell-aligned addresses the block has handed out and not yet freed (rough runs
	// may keep one after a free); unaligned grants (foreign frees coming back) are kept
	// out so two pooled addresses never share a link cell
	logic [ADDR_W-1:0] granted_q [$];
	// pages known to be carved; a free into any other page would read a tag
	// that was never written
	bit                page_live [DEF_POOL_PAGES];

	ssca_stream_if #(.payload_t(req_t)) req ();
	ssca_stream_if #(.payload_t(rsp_t)) rsp ();

	slab_size_class_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ssca_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_beat   (req.data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_beat   (rsp.data),
		.fail_count (fail_count),
		.due_count  (rsp_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// rsp back-pressure: mostly ready, short stalls, a few long ones, and
	// stretches with no stall at all
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_hold = 0;
			rx_run  = 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			rsp.ready <= 1'b0;
		end else if (rx_run > 0) begin
			rx_run--;
			rsp.ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(99);
			if (rx_roll < 12) begin
				rx_hold = $urandom_range(2);
				rsp.ready <= 1'b0;
			end else if (rx_roll < 15) begin
				rx_hold = $urandom_range(29, 9);
				rsp.ready <= 1'b0;
			end else begin
				if (rx_roll < 22)
					rx_run = $urandom_range(60, 20);
				rsp.ready <= 1'b1;
			end
		end
	end

	// track grants so frees can target live slots and live pages
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granted_q.delete();
			for (int p = 0; p < DEF_POOL_PAGES; p++)
				page_live[p] <= (p < NUM_CLASSES);
		end else if (rsp.valid && rsp.ready && rsp.data.status == ST_GRANT) begin
			page_live[rsp.data.addr[ADDR_W-1:OFFS_W]] <= 1'b1;
			if (rsp.data.addr[CELL_SHIFT-1:0] == '0)
				granted_q.push_back(rsp.data.addr);
		end
	end

	function automatic req_t mk_alloc(input logic [SIZE_W-1:0] size);
		req_t b;
		b.func      = FN_ALLOC;
		b.req_size  = size;
		b.free_addr = ADDR_W'($urandom);
		return b;
	endfunction

	function automatic req_t mk_free(input logic [ADDR_W-1:0] a);
		req_t b;
		b.func      = FN_FREE;
		b.req_size  = SIZE_W'($urandom);
		b.free_addr = a;
		return b;
	endfunction

	// a request size that lands in class k, edges of the class favored
	function automatic logic [SIZE_W-1:0] size_in_class(input int k);
		int lo;
		int hi;
		lo = (k == 0) ? 0 : (MIN_SLOT << (k - 1));
		hi = (MIN_SLOT << k) - 1;
		case ($urandom_range(7))
			0: return SIZE_W'(lo);
			1: return SIZE_W'(hi);
			default: return SIZE_W'($urandom_range(hi, lo));
		endcase
	endfunction

	// large request: anywhere in the field, or one byte around a page multiple
	function automatic logic [SIZE_W-1:0] large_size();
		int pages;
		if ($urandom_range(1) == 1)
			return SIZE_W'($urandom_range(24'hFFFFFF, LARGE_LIMIT));
		pages = $urandom_range(4095, 1);
		return SIZE_W'(pages * PAGE_BYTES + $urandom_range(2) - 1);
	endfunction

	// rough: allow double frees and foreign addresses anywhere in a live page.
	// Both can tie a free list into a loop for good, so they stay late in the run.
	function automatic logic [ADDR_W-1:0] pick_free_addr(input bit rough);
		int                roll;
		int                idx;
		int                pg;
		logic [ADDR_W-1:0] a;
		roll = $urandom_range(99);
		if (roll < 75 && granted_q.size() != 0) begin
			idx = $urandom_range(granted_q.size() - 1);
			a   = granted_q[idx];
			if (!rough || roll < 55)
				granted_q.delete(idx);
			return a;
		end
		if (roll < 88)
			return {PAGE_IDX_W'($urandom), OFFS_W'(0)};
		do
			pg = $urandom_range(LAST_PAGE);
		while (!page_live[pg]);
		// well-formed runs only use the page's first cell, which carving never grants
		if (rough)
			return {PAGE_IDX_W'(pg), OFFS_W'($urandom_range(PAGE_BYTES - 1, 1))};
		return {PAGE_IDX_W'(pg), OFFS_W'($urandom_range(MIN_SLOT - 1, 1))};
	endfunction

	function automatic req_t rand_item(input bit rough);
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return mk_alloc(size_in_class($urandom_range(NUM_CLASSES - 1)));
		if (roll < 50)
			return mk_alloc(large_size());
		return mk_free(pick_free_addr(rough));
	endfunction

	// one request beat; returns at the edge that accepts it, valid still high
	task automatic send_beat(input req_t b);
		int gap;
		int roll;
		gap = 0;
		if (tx_run > 0) begin
			tx_run--;
		end else begin
			roll = $urandom_range(99);
			if (roll < 10)
				tx_run = $urandom_range(40, 10);
			else if (roll < 30)
				gap = $urandom_range(3, 1);
			else if (roll < 36)
				gap = $urandom_range(30, 8);
		end
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= b;
		// ready only moves at rising edges, so the falling edge tells whether
		// the next rising edge takes the beat
		do
			@(negedge clk);
		while (!req.ready);
		@(posedge clk);
	endtask

	// hold off until every response owed has come back
	task automatic wait_rsp_drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (rsp_due != 0);
	endtask

	initial begin
		req_t b;
		int   roll;

		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: class edges, carving across a page, large sizes, page frees
		send_beat(mk_alloc(24'd0));        // zero size -> class 0, top slot of page 0
		send_beat(mk_alloc(24'd7));
		send_beat(mk_alloc(24'd8));        // exactly a slot size moves up a class
		send_beat(mk_alloc(24'd16));       // class 2
		send_beat(mk_alloc(24'd511));
		send_beat(mk_alloc(24'd512));      // class 7 carves page 7 from the top
		send_beat(mk_alloc(24'd1023));
		send_beat(mk_alloc(24'd768));      // page 7 now used up
		send_beat(mk_alloc(24'd1000));     // takes a fresh page from the pool
		send_beat(mk_alloc(24'd1024));     // smallest large request
		send_beat(mk_alloc(24'd4096));
		send_beat(mk_alloc(24'd4097));
		send_beat(mk_alloc(24'hFFFFFF));   // max page count
		send_beat(mk_free(18'h00000));     // page-aligned frees pass straight out
		send_beat(mk_free(18'h3F000));
		send_beat(mk_free(18'd4088));      // push then pop on class 0
		send_beat(mk_alloc(24'd1));
		// two addresses in one link cell: class 2 list ends up looping on itself
		send_beat(mk_free(18'd12256));
		send_beat(mk_free(18'd12260));
		send_beat(mk_alloc(24'd31));
		send_beat(mk_alloc(24'd17));
		// unaligned and foreign addresses go onto the list as given
		send_beat(mk_free(18'd4095));
		send_beat(mk_alloc(24'd3));
		send_beat(mk_free(18'd4101));
		send_beat(mk_alloc(24'd9));

		// well-formed traffic: each granted slot freed at most once
		for (int n = 0; n < 220; n++)
			send_beat(rand_item(1'b0));
		wait_rsp_drain();

		// mostly big slots to run the pool out of pages
		for (int n = 0; n < 260; n++) begin
			roll = $urandom_range(99);
			if (roll < 70)
				b = mk_alloc(size_in_class(NUM_CLASSES - 1));
			else if (roll < 82)
				b = mk_alloc(size_in_class($urandom_range(6, 5)));
			else if (roll < 92)
				b = mk_alloc(size_in_class($urandom_range(4)));
			else
				b = mk_free(pick_free_addr(1'b0));
			send_beat(b);
		end
		wait_rsp_drain();

		// pool exhausted: double frees, foreign addresses, out-of-page grants
		for (int n = 0; n < 140; n++)
			send_beat(rand_item(1'b1));

		wait_rsp_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && rsp_due == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
